// File: design/gdnc_pkg.sv
// Constants, reciprocals, month tables and pipeline stage types for the day-number converter.
package gdnc_pkg;

  // Field widths
  localparam int MJD_W   = 23;
  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 9;
  localparam int WEEK_W  = 6;
  localparam int DOM_W   = 5;
  localparam int WDAY_W  = 3;
  localparam int CMD_W   = 2;
  localparam int ERR_W   = 2;

  // Calendar constants
  localparam int MJD_MIN   = -678575;   // 0001-01-01
  localparam int MJD_MAX   = 2973483;   // 9999-12-31
  localparam int MJD_DAY1  = 678575;    // days from 0001-01-01 to MJD 0
  localparam int YEAR_MAX  = 9999;
  localparam int DAYS_YEAR = 365;
  localparam int DAYS_4Y   = 1461;
  localparam int DAYS_100Y = 36524;
  localparam int DAYS_400Y = 146097;
  localparam int DAYS_WEEK = 7;

  // Reciprocals: floor(x / D) == (x * RCP) >> SH for every x of the stated width
  localparam int SH_400Y = 40;  // 22-bit day count
  localparam logic [22:0] RCP_400Y =
    23'(((64'd1 << SH_400Y) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y));
  localparam int SH_WK22 = 25;  // 22-bit day count
  localparam logic [22:0] RCP_WK22 =
    23'(((64'd1 << SH_WK22) + 64'(DAYS_WEEK) - 64'd1) / 64'(DAYS_WEEK));
  localparam int SH_C100 = 21;  // 14-bit year
  localparam logic [14:0] RCP_C100 = 15'(((64'd1 << SH_C100) + 64'd99) / 64'd100);
  localparam int SH_WK14 = 17;  // 14-bit weekday sum
  localparam logic [14:0] RCP_WK14 =
    15'(((64'd1 << SH_WK14) + 64'(DAYS_WEEK) - 64'd1) / 64'(DAYS_WEEK));
  localparam int SH_4Y = 27;    // 16-bit day within a century
  localparam logic [16:0] RCP_4Y =
    17'(((64'd1 << SH_4Y) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));
  localparam int SH_WK9 = 11;   // values up to 375
  localparam logic [8:0] RCP_WK9 = 9'd293;

  typedef enum logic [CMD_W-1:0] {
    CMD_SPLIT = 2'd0,  // day number to date
    CMD_CAL   = 2'd1,  // calendar date to day number
    CMD_ORD   = 2'd2,  // ordinal date to day number
    CMD_ISO   = 2'd3   // ISO week date to day number
  } cmd_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_MONTH = 2'd1,
    ERR_DAY   = 2'd2,
    ERR_RANGE = 2'd3
  } err_t;

  // Length of month m
  function automatic logic [DOM_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DOM_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in the year before the first of month m
  function automatic logic [DAY_W-1:0] days_before(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DAY_W-1:0] cum;
    case (m)
      4'd1:    cum = 9'd0;
      4'd2:    cum = 9'd31;
      4'd3:    cum = 9'd59;
      4'd4:    cum = 9'd90;
      4'd5:    cum = 9'd120;
      4'd6:    cum = 9'd151;
      4'd7:    cum = 9'd181;
      4'd8:    cum = 9'd212;
      4'd9:    cum = 9'd243;
      4'd10:   cum = 9'd273;
      4'd11:   cum = 9'd304;
      4'd12:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    if (leap && m >= 4'd3 && m <= 4'd12) begin
      cum = cum + 9'd1;
    end
    return cum;
  endfunction

  // Pipeline stage contents
  typedef struct packed {
    cmd_t              cmd;
    logic              bad;
    logic [21:0]       n;      // days since 0001-01-01
    logic [4:0]        q400;
    logic [18:0]       q7n;
    logic [YEAR_W-1:0] e;      // year - 1
    logic [6:0]        h;      // (year - 1) / 100
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [WEEK_W-1:0] week;
  } st1_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              bad;
    logic [4:0]        q400;
    logic [17:0]       r;      // day within the 400-year cycle
    logic [WDAY_W-1:0] wd;
    logic [21:0]       ndays;  // days from 0001-01-01 to January 1st
    logic [YEAR_W-1:0] wsum;   // sum congruent to the same count modulo 7
    logic              leap;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [WEEK_W-1:0] week;
  } st2_t;

  typedef struct packed {
    cmd_t              cmd;
    logic              bad;
    logic [4:0]        q400;
    logic [1:0]        c;
    logic [15:0]       r2;
    logic [WDAY_W-1:0] wd;
    logic [21:0]       ndays;
    logic [YEAR_W-1:0] wsum;
    logic [10:0]       q7s;
    logic              leap;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]  day;
    logic [WEEK_W-1:0] week;
  } st3_t;

  typedef struct packed {
    cmd_t              cmd;
    err_t              err;
    logic [4:0]        q400;
    logic [1:0]        c;
    logic [4:0]        f;
    logic [15:0]       r2;
    logic [WDAY_W-1:0] wd;
    logic [21:0]       ndays;
    logic [9:0]        offset; // two's complement day offset from January 1st
  } st4_t;

  typedef struct packed {
    cmd_t              cmd;
    err_t              err;
    logic [4:0]        q400;
    logic [1:0]        c;
    logic [4:0]        f;
    logic [10:0]       r3;
    logic [WDAY_W-1:0] wd;
    logic [MJD_W-1:0]  mjd;
  } st5_t;

  typedef struct packed {
    cmd_t              cmd;
    err_t              err;
    logic [YEAR_W-1:0] year;
    logic [DAY_W-1:0]  doy;
    logic              leap;
    logic              pleap;  // previous year is leap
    logic [WDAY_W-1:0] wd;
    logic [MJD_W-1:0]  mjd;
  } st6_t;

  typedef struct packed {
    cmd_t              cmd;
    err_t              err;
    logic [YEAR_W-1:0] year;
    logic [DAY_W-1:0]  doy;
    logic              leap;
    logic              pleap;
    logic [WDAY_W-1:0] wd;
    logic [MJD_W-1:0]  mjd;
    logic [MONTH_W-1:0] month;
    logic [5:0]        qd;     // (doy - 1) / 7
    logic [5:0]        qw;     // (doy - wd + 10) / 7
  } st7_t;

endpackage

// File: design/gregorian_day_number_converter.sv
// Top level: pipelined converter between modified Julian day and Gregorian dates.
//
//  port group   direction  handshake            payload
//  in_*         request    start / busy         in_cmd, in_mjd, in_year, in_month,
//                                               in_day, in_week
//  out_*        result     out_valid (strobe)   out_mjd_out .. out_iso_weekday, out_error
//
// A request is taken at every clock edge with start high; busy is always low.
// Each request gives one result, in order, after passing the input register, the
// stage registers and the result register. The depth is set by the chain of steps
// (400-, 100-, 4- and 1-year cycles, then month and ISO week), using reciprocal multiplies or compares.
// Reset clears only the stage valid bits and the result strobe; the receiver cannot stall the output.
module gregorian_day_number_converter (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [gdnc_pkg::CMD_W-1:0]            in_cmd,
  input  logic signed [gdnc_pkg::MJD_W-1:0]     in_mjd,
  input  logic [gdnc_pkg::YEAR_W-1:0]           in_year,
  input  logic [gdnc_pkg::MONTH_W-1:0]          in_month,
  input  logic [gdnc_pkg::DAY_W-1:0]            in_day,
  input  logic [gdnc_pkg::WEEK_W-1:0]           in_week,
  output logic                                  out_valid,
  output logic signed [gdnc_pkg::MJD_W-1:0]     out_mjd_out,
  output logic [gdnc_pkg::YEAR_W-1:0]           out_year_out,
  output logic [gdnc_pkg::MONTH_W-1:0]          out_month_out,
  output logic [gdnc_pkg::DOM_W-1:0]            out_day_of_month,
  output logic [gdnc_pkg::DAY_W-1:0]            out_day_of_year,
  output logic [gdnc_pkg::YEAR_W-1:0]           out_iso_year,
  output logic [gdnc_pkg::WEEK_W-1:0]           out_iso_week,
  output logic [gdnc_pkg::WDAY_W-1:0]           out_iso_weekday,
  output logic [gdnc_pkg::ERR_W-1:0]            out_error
);
  import gdnc_pkg::*;

  localparam int NSTG = 8;  // input register plus seven work stages

  // Stage valid bits and result strobe
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic            ovld_r;

  // Input register
  cmd_t               p0_cmd_r;
  logic [MJD_W-1:0]   p0_mjd_r;
  logic [YEAR_W-1:0]  p0_year_r;
  logic [MONTH_W-1:0] p0_month_r;
  logic [DAY_W-1:0]   p0_day_r;
  logic [WEEK_W-1:0]  p0_week_r;

  st1_t s1_r, s1_nxt;
  st2_t s2_r, s2_nxt;
  st3_t s3_r, s3_nxt;
  st4_t s4_r, s4_nxt;
  st5_t s5_r, s5_nxt;
  st6_t s6_r, s6_nxt;
  st7_t s7_r, s7_nxt;

  // Result register
  logic [MJD_W-1:0]   o_mjd_r,   o_mjd_nxt;
  logic [YEAR_W-1:0]  o_year_r,  o_year_nxt;
  logic [MONTH_W-1:0] o_month_r, o_month_nxt;
  logic [DOM_W-1:0]   o_dom_r,   o_dom_nxt;
  logic [DAY_W-1:0]   o_doy_r,   o_doy_nxt;
  logic [YEAR_W-1:0]  o_iyear_r, o_iyear_nxt;
  logic [WEEK_W-1:0]  o_iweek_r, o_iweek_nxt;
  logic [WDAY_W-1:0]  o_iwday_r, o_iwday_nxt;
  err_t               o_err_r,   o_err_nxt;

  assign busy = 1'b0;

  // Stage 0: day count from 0001-01-01, range checks, first reciprocals
  always_comb begin
    logic signed [MJD_W:0] n_full;
    logic                  mjd_ok;
    logic                  year_ok;
    logic [44:0]           prod_q;
    logic [44:0]           prod_w;
    logic [28:0]           prod_h;
    n_full  = (MJD_W+1)'(signed'(p0_mjd_r)) + (MJD_W+1)'(MJD_DAY1);
    mjd_ok  = (signed'(p0_mjd_r) >= MJD_W'(MJD_MIN)) &&
              (signed'(p0_mjd_r) <= MJD_W'(MJD_MAX));
    year_ok = (p0_year_r != '0) && (p0_year_r <= YEAR_W'(YEAR_MAX));
    s1_nxt.cmd   = p0_cmd_r;
    s1_nxt.bad   = (p0_cmd_r == CMD_SPLIT) ? !mjd_ok : !year_ok;
    s1_nxt.n     = n_full[21:0];
    prod_q       = 45'(s1_nxt.n) * 45'(RCP_400Y);
    s1_nxt.q400  = 5'(prod_q >> SH_400Y);
    prod_w       = 45'(s1_nxt.n) * 45'(RCP_WK22);
    s1_nxt.q7n   = 19'(prod_w >> SH_WK22);
    s1_nxt.e     = p0_year_r - YEAR_W'(1);
    prod_h       = 29'(s1_nxt.e) * 29'(RCP_C100);
    s1_nxt.h     = 7'(prod_h >> SH_C100);
    s1_nxt.month = p0_month_r;
    s1_nxt.day   = p0_day_r;
    s1_nxt.week  = p0_week_r;
  end

  // Stage 1: remainder in the 400-year cycle, weekday, day count of January 1st
  always_comb begin
    logic [21:0]       r_full;
    logic [21:0]       wmod;
    logic [YEAR_W-1:0] r100;
    r_full = s1_r.n - 22'(s1_r.q400) * 22'(DAYS_400Y);
    wmod   = s1_r.n - 22'(s1_r.q7n) * 22'(DAYS_WEEK);
    r100   = s1_r.e - YEAR_W'(s1_r.h) * YEAR_W'(100);
    s2_nxt.cmd   = s1_r.cmd;
    s2_nxt.bad   = s1_r.bad;
    s2_nxt.q400  = s1_r.q400;
    s2_nxt.r     = r_full[17:0];
    s2_nxt.wd    = wmod[2:0] + 3'd1;
    s2_nxt.ndays = 22'(s1_r.e) * 22'(DAYS_YEAR) + 22'(s1_r.e >> 2)
                   - 22'(s1_r.h) + 22'(s1_r.h >> 2);
    s2_nxt.wsum  = s1_r.e + (s1_r.e >> 2) - YEAR_W'(s1_r.h) + YEAR_W'(s1_r.h >> 2);
    // year % 4 == 0, and a century year only when year % 400 == 0
    s2_nxt.leap  = (s1_r.e[1:0] == 2'd3) &&
                   ((r100 != YEAR_W'(99)) || (s1_r.h[1:0] == 2'd3));
    s2_nxt.month = s1_r.month;
    s2_nxt.day   = s1_r.day;
    s2_nxt.week  = s1_r.week;
  end

  // Stage 2: century within the cycle, weekday reciprocal for January 1st
  always_comb begin
    logic [1:0]  c;
    logic [28:0] prod_s;
    if (s2_r.r >= 18'(3 * DAYS_100Y)) begin
      c = 2'd3;
    end else if (s2_r.r >= 18'(2 * DAYS_100Y)) begin
      c = 2'd2;
    end else if (s2_r.r >= 18'(DAYS_100Y)) begin
      c = 2'd1;
    end else begin
      c = 2'd0;
    end
    prod_s = 29'(s2_r.wsum) * 29'(RCP_WK14);
    s3_nxt.cmd   = s2_r.cmd;
    s3_nxt.bad   = s2_r.bad;
    s3_nxt.q400  = s2_r.q400;
    s3_nxt.c     = c;
    s3_nxt.r2    = 16'(s2_r.r - 18'(c) * 18'(DAYS_100Y));
    s3_nxt.wd    = s2_r.wd;
    s3_nxt.ndays = s2_r.ndays;
    s3_nxt.wsum  = s2_r.wsum;
    s3_nxt.q7s   = 11'(prod_s >> SH_WK14);
    s3_nxt.leap  = s2_r.leap;
    s3_nxt.month = s2_r.month;
    s3_nxt.day   = s2_r.day;
    s3_nxt.week  = s2_r.week;
  end

  // Stage 3: 4-year cycle, request checks and day offset for commands 1 to 3
  always_comb begin
    logic [32:0]       prod_f;
    logic [YEAR_W-1:0] jmod;
    logic [2:0]        jwd;
    logic [9:0]        mon_off;
    logic [DAY_W-1:0]  ylen;
    err_t              err;
    logic [9:0]        offset;
    prod_f = 33'(s3_r.r2) * 33'(RCP_4Y);
    jmod   = s3_r.wsum - YEAR_W'(s3_r.q7s) * YEAR_W'(DAYS_WEEK);
    jwd    = jmod[2:0] + 3'd1;
    // Monday of ISO week 1 relative to January 1st
    mon_off = (jwd > 3'd4) ? (10'd8 - 10'(jwd)) : (10'd1 - 10'(jwd));
    ylen    = s3_r.leap ? 9'd366 : 9'd365;
    err     = ERR_OK;
    offset  = '0;
    case (s3_r.cmd)
      CMD_CAL: begin
        if (s3_r.month < 4'd1 || s3_r.month > 4'd12) begin
          err = ERR_MONTH;
        end else if (s3_r.day < 9'd1 ||
                     s3_r.day > 9'(month_len(s3_r.month, s3_r.leap))) begin
          err = ERR_DAY;
        end
        offset = 10'(days_before(s3_r.month, s3_r.leap)) + 10'(s3_r.day) - 10'd1;
      end
      CMD_ORD: begin
        if (s3_r.day < 9'd1 || s3_r.day > ylen) begin
          err = ERR_DAY;
        end
        offset = 10'(s3_r.day) - 10'd1;
      end
      CMD_ISO: begin
        if (s3_r.week < 6'd1 || s3_r.week > 6'd53) begin
          err = ERR_MONTH;
        end else if (s3_r.day < 9'd1 || s3_r.day > 9'd7) begin
          err = ERR_DAY;
        end
        offset = mon_off + 10'(s3_r.week) * 10'(DAYS_WEEK) - 10'(DAYS_WEEK)
                 + 10'(s3_r.day) - 10'd1;
      end
      default: begin
        err    = ERR_OK;
        offset = '0;
      end
    endcase
    s4_nxt.cmd    = s3_r.cmd;
    s4_nxt.err    = s3_r.bad ? ERR_RANGE : err;
    s4_nxt.q400   = s3_r.q400;
    s4_nxt.c      = s3_r.c;
    s4_nxt.f      = 5'(prod_f >> SH_4Y);
    s4_nxt.r2     = s3_r.r2;
    s4_nxt.wd     = s3_r.wd;
    s4_nxt.ndays  = s3_r.ndays;
    s4_nxt.offset = offset;
  end

  // Stage 4: day within the 4-year cycle, day number for commands 1 to 3
  always_comb begin
    s5_nxt.cmd  = s4_r.cmd;
    s5_nxt.err  = s4_r.err;
    s5_nxt.q400 = s4_r.q400;
    s5_nxt.c    = s4_r.c;
    s5_nxt.f    = s4_r.f;
    s5_nxt.r3   = 11'(s4_r.r2 - 16'(s4_r.f) * 16'(DAYS_4Y));
    s5_nxt.wd   = s4_r.wd;
    s5_nxt.mjd  = MJD_W'(s4_r.ndays) - MJD_W'(MJD_DAY1)
                  + MJD_W'(signed'(s4_r.offset));
  end

  // Stage 5: year within the 4-year cycle, day of year, year and leap flags
  always_comb begin
    logic [1:0] y0;
    if (s5_r.r3 >= 11'(3 * DAYS_YEAR)) begin
      y0 = 2'd3;
    end else if (s5_r.r3 >= 11'(2 * DAYS_YEAR)) begin
      y0 = 2'd2;
    end else if (s5_r.r3 >= 11'(DAYS_YEAR)) begin
      y0 = 2'd1;
    end else begin
      y0 = 2'd0;
    end
    s6_nxt.cmd   = s5_r.cmd;
    s6_nxt.err   = s5_r.err;
    s6_nxt.doy   = 9'(s5_r.r3 - 11'(y0) * 11'(DAYS_YEAR) + 11'd1);
    s6_nxt.year  = YEAR_W'(1) + YEAR_W'(s5_r.q400) * YEAR_W'(400)
                   + YEAR_W'(s5_r.c) * YEAR_W'(100) + YEAR_W'(s5_r.f) * YEAR_W'(4)
                   + YEAR_W'(y0);
    // last year of a 4-year group; century years only at the end of the 400-year cycle
    s6_nxt.leap  = (y0 == 2'd3) && ((s5_r.f != 5'd24) || (s5_r.c == 2'd3));
    s6_nxt.pleap = (y0 == 2'd0) && ((s5_r.f != 5'd0) || (s5_r.c == 2'd0));
    s6_nxt.wd    = s5_r.wd;
    s6_nxt.mjd   = s5_r.mjd;
  end

  // Stage 6: month search, week reciprocals
  always_comb begin
    logic [MONTH_W-1:0] m;
    logic [DAY_W-1:0]   x;
    logic [17:0]        prod_d;
    logic [17:0]        prod_x;
    m = 4'd1;
    for (int k = 2; k <= 12; k++) begin
      if (s6_r.doy > days_before(MONTH_W'(k), s6_r.leap)) begin
        m = MONTH_W'(k);
      end
    end
    x      = s6_r.doy + 9'd10 - 9'(s6_r.wd);
    prod_d = 18'(s6_r.doy - 9'd1) * 18'(RCP_WK9);
    prod_x = 18'(x) * 18'(RCP_WK9);
    s7_nxt.cmd   = s6_r.cmd;
    s7_nxt.err   = s6_r.err;
    s7_nxt.year  = s6_r.year;
    s7_nxt.doy   = s6_r.doy;
    s7_nxt.leap  = s6_r.leap;
    s7_nxt.pleap = s6_r.pleap;
    s7_nxt.wd    = s6_r.wd;
    s7_nxt.mjd   = s6_r.mjd;
    s7_nxt.month = m;
    s7_nxt.qd    = 6'(prod_d >> SH_WK9);
    s7_nxt.qw    = 6'(prod_x >> SH_WK9);
  end

  // Stage 7: day of month, ISO year and week, result selection
  always_comb begin
    logic [DAY_W-1:0]  dmod;
    logic [2:0]        d7;
    logic [2:0]        jwd;
    logic              long_cur;
    logic              long_prev;
    logic [YEAR_W-1:0] iyear;
    logic [WEEK_W-1:0] iweek;
    dmod = (s7_r.doy - 9'd1) - 9'(s7_r.qd) * 9'(DAYS_WEEK);
    d7   = dmod[2:0];
    // weekday of January 1st
    jwd  = (s7_r.wd > d7) ? (s7_r.wd - d7) : 3'(4'(s7_r.wd) + 4'd7 - 4'(d7));
    // 53-week years start on Thursday, or on Wednesday when leap
    long_cur  = (jwd == 3'd4) || (s7_r.leap && (jwd == 3'd3));
    long_prev = (jwd == 3'd5) || (s7_r.pleap && (jwd == 3'd6));
    if (s7_r.qw == 6'd0) begin
      iyear = s7_r.year - YEAR_W'(1);
      iweek = long_prev ? 6'd53 : 6'd52;
    end else if ((s7_r.qw == 6'd53) && !long_cur) begin
      iyear = s7_r.year + YEAR_W'(1);
      iweek = 6'd1;
    end else begin
      iyear = s7_r.year;
      iweek = s7_r.qw;
    end
    o_err_nxt   = s7_r.err;
    o_mjd_nxt   = '0;
    o_year_nxt  = '0;
    o_month_nxt = '0;
    o_dom_nxt   = '0;
    o_doy_nxt   = '0;
    o_iyear_nxt = '0;
    o_iweek_nxt = '0;
    o_iwday_nxt = '0;
    if (s7_r.err == ERR_OK) begin
      if (s7_r.cmd == CMD_SPLIT) begin
        o_year_nxt  = s7_r.year;
        o_month_nxt = s7_r.month;
        o_dom_nxt   = 5'(s7_r.doy - days_before(s7_r.month, s7_r.leap));
        o_doy_nxt   = s7_r.doy;
        o_iyear_nxt = iyear;
        o_iweek_nxt = iweek;
        o_iwday_nxt = s7_r.wd;
      end else begin
        o_mjd_nxt = s7_r.mjd;
      end
    end
  end

  // Valid pipeline
  assign vld_nxt = {vld_r[NSTG-2:0], start};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      vld_r  <= vld_nxt;
      ovld_r <= vld_r[NSTG-1];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    p0_cmd_r   <= cmd_t'(in_cmd);
    p0_mjd_r   <= in_mjd;
    p0_year_r  <= in_year;
    p0_month_r <= in_month;
    p0_day_r   <= in_day;
    p0_week_r  <= in_week;
    s1_r       <= s1_nxt;
    s2_r       <= s2_nxt;
    s3_r       <= s3_nxt;
    s4_r       <= s4_nxt;
    s5_r       <= s5_nxt;
    s6_r       <= s6_nxt;
    s7_r       <= s7_nxt;
    o_mjd_r    <= o_mjd_nxt;
    o_year_r   <= o_year_nxt;
    o_month_r  <= o_month_nxt;
    o_dom_r    <= o_dom_nxt;
    o_doy_r    <= o_doy_nxt;
    o_iyear_r  <= o_iyear_nxt;
    o_iweek_r  <= o_iweek_nxt;
    o_iwday_r  <= o_iwday_nxt;
    o_err_r    <= o_err_nxt;
  end

  // Result ports
  assign out_valid        = ovld_r;
  assign out_mjd_out      = o_mjd_r;
  assign out_year_out     = o_year_r;
  assign out_month_out    = o_month_r;
  assign out_day_of_month = o_dom_r;
  assign out_day_of_year  = o_doy_r;
  assign out_iso_year     = o_iyear_r;
  assign out_iso_week     = o_iweek_r;
  assign out_iso_weekday  = o_iwday_r;
  assign out_error        = o_err_r;

endmodule
